// ===== src/utc_pkg.sv =====
// Shared types, codes and decode helpers for the UTF-8 token code speller.
package utc_pkg;

   typedef struct packed {
      logic       action;
      logic [7:0] data_byte;
      logic       has_byte;
      logic       end_of_message;
   } req_type;

   typedef struct packed {
      logic [20:0] code;
      logic [8:0]  code_total;
      logic [2:0]  status;
      logic        last;
   } rsp_type;

   localparam logic       ACT_FEED = 1'b0;
   localparam logic       ACT_READ = 1'b1;

   localparam logic [2:0] ST_CODE     = 3'd0;
   localparam logic [2:0] ST_READY    = 3'd1;
   localparam logic [2:0] ST_NOTHING  = 3'd2;
   localparam logic [2:0] ST_OVERFLOW = 3'd3;
   localparam logic [2:0] ST_NONE     = 3'd4;

   localparam logic REG_MIN_SIZE  = 1'b0;
   localparam logic REG_FILL_CODE = 1'b1;

   localparam logic [20:0] SPACE_CODE = 21'd32;
   localparam logic [20:0] TOP_CODE   = 21'h10FFFF;

   function automatic logic [1:0] lead_extra(input logic [7:0] b);
      logic [1:0] n;
      n = 2'd0;
      if ((b & 8'hE0) == 8'hC0) n = 2'd1;
      else if ((b & 8'hF0) == 8'hE0) n = 2'd2;
      else if ((b & 8'hF8) == 8'hF0) n = 2'd3;
      return n;
   endfunction

   function automatic logic is_blank(input logic [7:0] b);
      return (b == 8'h20) || (b == 8'h09) || (b == 8'h0A) || (b == 8'h0D);
   endfunction

   function automatic logic [20:0] seq_value(input logic [3:0][7:0] p,
                                             input logic [1:0] need);
      logic [20:0] c;
      case (need)
         2'd1: begin
            c = {10'd0, p[0][4:0], p[1][5:0]};
         end
         2'd2: begin
            c = {5'd0, p[0][3:0], p[1][5:0], p[2][5:0]};
         end
         2'd3: begin
            c = {p[0][2:0], p[1][5:0], p[2][5:0], p[3][5:0]};
         end
         default: begin
            c = 21'd0;
         end
      endcase
      return c;
   endfunction

   function automatic logic seq_valid(input logic [20:0] c, input logic [1:0] need);
      logic ok;
      case (need)
         2'd1: begin
            ok = c >= 21'h80;
         end
         2'd2: begin
            ok = (c >= 21'h800) && !((c >= 21'hD800) && (c <= 21'hDFFF));
         end
         2'd3: begin
            ok = (c >= 21'h10000) && (c <= TOP_CODE);
         end
         default: begin
            ok = 1'b0;
         end
      endcase
      return ok;
   endfunction

endpackage

// ===== src/utc_code_store.sv =====
// Code store: one write port, one registered read port.
module utc_code_store
   import utc_pkg::*;
#(
   parameter int DEPTH = 256,
   parameter int AW    = 8
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [20:0]   wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [20:0]   rd_data
);

   logic [20:0] mem [DEPTH];
   logic [20:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/utf8_token_code_speller.sv =====
// Top level of the UTF-8 token code speller.
//
// Use: an item is taken when start is high and busy is low. A feed item
// (action 0) carries one message byte and/or the end mark; a read item
// (action 1) fetches the next code of a finished message.
// Every item that yields a result shows it on rsp_payload for one cycle
// with rsp_strobe high; the receiver cannot stall, so nothing is held back.
// A feed without byte or end mark is taken and ignored at once.
// A feed byte keeps busy high while its codes go one code per cycle into
// the code store (up to four codes from a failed sequence, plus a flush of
// held bytes at the end mark), so no new item is taken before they are
// written. An end mark adds a flush of held bytes and the finish step;
// its status beat follows. Padding costs nothing: fill codes are produced
// at readout. A read item's beat passes the registered store read and then
// the response register; a read with no message pending gives its beat
// on the next cycle.
// Registers on the csr_ port are always ready and should be written only
// while the block is idle. Reset clears all control state, minimum_size to
// 0 and fill_code to 32; the store needs no clearing.
module utf8_token_code_speller
   import utc_pkg::*;
#(
   parameter int MAX_CODE_COUNT = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_payload,
   output logic        rsp_strobe,
   output rsp_type     rsp_payload,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [20:0] csr_data
);

   localparam int CW = $clog2(MAX_CODE_COUNT + 1);
   localparam int AW = $clog2(MAX_CODE_COUNT);
   localparam int TW = (CW > 9) ? CW : 9;

   typedef enum logic [3:0] {
      S_IDLE, S_BYTE, S_DECODE, S_CHECK, S_FLUSH, S_EOM, S_FINISH, S_RDOUT
   } state_type;

   state_type     state_ff, state_in;
   state_type     flush_next_ff, flush_next_in;
   req_type       item_ff, item_in;
   logic [3:0][7:0] pend_ff, pend_in;
   logic [2:0]    pend_cnt_ff, pend_cnt_in;
   logic [2:0]    flush_idx_ff, flush_idx_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] total_ff, total_in;
   logic [CW-1:0] rd_idx_ff, rd_idx_in;
   logic          token_ff, token_in;
   logic          space_ff, space_in;
   logic          ovf_ff, ovf_in;
   logic          ready_ff, ready_in;
   logic [8:0]    min_size_ff, min_size_in;
   logic [20:0]   fill_code_ff, fill_code_in;
   logic [20:0]   fill_lat_ff, fill_lat_in;
   logic          rsp_strobe_ff, rsp_strobe_in;
   rsp_type       rsp_ff, rsp_in;

   logic          put_en;
   logic [20:0]   put_code;
   logic          wr_en;
   logic          rd_en;
   logic [20:0]   rd_data;
   logic          accept;
   logic [1:0]    need;
   logic [20:0]   seq_code;
   logic [TW-1:0] min_w;
   logic [CW-1:0] min_eff;
   logic [CW-1:0] total_new;
   logic [CW-1:0] rd_next;
   logic [TW-1:0] tot_w;

   assign accept    = start && !busy;
   assign busy      = state_ff != S_IDLE;
   assign csr_ready = 1'b1;
   assign need      = lead_extra(pend_ff[0]);
   assign seq_code  = seq_value(pend_ff, need);
   assign min_w     = (TW'(min_size_ff) > TW'(MAX_CODE_COUNT)) ?
                      TW'(MAX_CODE_COUNT) : TW'(min_size_ff);
   assign min_eff   = CW'(min_w);
   assign total_new = (cnt_ff >= min_eff) ? cnt_ff : min_eff;
   assign rd_next   = rd_idx_ff + CW'(1);
   assign tot_w     = TW'(total_ff);
   assign rd_en     = accept && (req_payload.action == ACT_READ);
   assign wr_en     = put_en && !ovf_ff && (cnt_ff < CW'(MAX_CODE_COUNT));

   utc_code_store #(
      .DEPTH (MAX_CODE_COUNT),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cnt_ff[AW-1:0]),
      .wr_data (put_code),
      .rd_en   (rd_en),
      .rd_addr (rd_idx_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      logic clear_msg;
      logic clear_pend;
      clear_msg     = 1'b0;
      clear_pend    = 1'b0;
      state_in      = state_ff;
      flush_next_in = flush_next_ff;
      item_in       = item_ff;
      pend_in       = pend_ff;
      pend_cnt_in   = pend_cnt_ff;
      flush_idx_in  = flush_idx_ff;
      cnt_in        = cnt_ff;
      total_in      = total_ff;
      rd_idx_in     = rd_idx_ff;
      token_in      = token_ff;
      space_in      = space_ff;
      ovf_in        = ovf_ff;
      ready_in      = ready_ff;
      min_size_in   = min_size_ff;
      fill_code_in  = fill_code_ff;
      fill_lat_in   = fill_lat_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      put_en        = 1'b0;
      put_code      = 21'(item_ff.data_byte);

      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_MIN_SIZE: begin
               min_size_in = csr_data[8:0];
            end
            REG_FILL_CODE: begin
               fill_code_in = csr_data;
            end
            default: begin
            end
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               item_in = req_payload;
               if (req_payload.action == ACT_READ) begin
                  if (!ready_ff || (rd_idx_ff >= total_ff)) begin
                     rsp_strobe_in = 1'b1;
                     rsp_in        = '{code: 21'd0, code_total: 9'd0,
                                       status: ST_NONE, last: 1'b0};
                  end else begin
                     state_in = S_RDOUT;
                  end
               end else if (req_payload.has_byte || req_payload.end_of_message) begin
                  if (ready_ff) begin
                     ready_in  = 1'b0;
                     clear_msg = 1'b1;
                  end
                  state_in = req_payload.has_byte ? S_BYTE : S_EOM;
               end
            end
         end
         S_BYTE: begin
            if (is_blank(item_ff.data_byte)) begin
               if (token_ff) space_in = 1'b1;
               flush_next_in = S_EOM;
               state_in      = S_FLUSH;
            end else begin
               if (space_ff) begin
                  put_en   = 1'b1;
                  put_code = SPACE_CODE;
                  space_in = 1'b0;
               end
               token_in = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (pend_cnt_ff != 3'd0 && item_ff.data_byte[7:6] != 2'b10) begin
               flush_next_in = S_DECODE;
               state_in      = S_FLUSH;
            end else if (pend_cnt_ff != 3'd0) begin
               pend_in[pend_cnt_ff[1:0]] = item_ff.data_byte;
               pend_cnt_in               = pend_cnt_ff + 3'd1;
               state_in                  = S_CHECK;
            end else begin
               if (lead_extra(item_ff.data_byte) != 2'd0) begin
                  pend_in[0]  = item_ff.data_byte;
                  pend_cnt_in = 3'd1;
               end else begin
                  put_en   = 1'b1;
                  put_code = 21'(item_ff.data_byte);
               end
               state_in = S_EOM;
            end
         end
         S_CHECK: begin
            if (pend_cnt_ff < 3'(need) + 3'd1) begin
               state_in = S_EOM;
            end else if (seq_valid(seq_code, need)) begin
               put_en     = 1'b1;
               put_code   = seq_code;
               clear_pend = 1'b1;
               state_in   = S_EOM;
            end else begin
               flush_next_in = S_EOM;
               state_in      = S_FLUSH;
            end
         end
         S_FLUSH: begin
            if (flush_idx_ff == pend_cnt_ff) begin
               clear_pend = 1'b1;
               state_in   = flush_next_ff;
            end else begin
               put_en       = 1'b1;
               put_code     = 21'(pend_ff[flush_idx_ff[1:0]]);
               flush_idx_in = flush_idx_ff + 3'd1;
            end
         end
         S_EOM: begin
            if (item_ff.end_of_message) begin
               flush_next_in = S_FINISH;
               state_in      = S_FLUSH;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_FINISH: begin
            rsp_strobe_in = 1'b1;
            rsp_in        = '{code: 21'd0, code_total: 9'd0,
                              status: ST_OVERFLOW, last: 1'b0};
            state_in      = S_IDLE;
            if (ovf_ff) begin
               clear_msg = 1'b1;
            end else if (total_new == CW'(0)) begin
               rsp_in.status = ST_NOTHING;
               clear_msg     = 1'b1;
            end else begin
               total_in          = total_new;
               fill_lat_in       = (fill_code_ff > TOP_CODE) ? SPACE_CODE : fill_code_ff;
               token_in          = 1'b0;
               space_in          = 1'b0;
               rd_idx_in         = '0;
               ready_in          = 1'b1;
               rsp_in.status     = ST_READY;
               rsp_in.code_total = 9'(TW'(total_new));
            end
         end
         S_RDOUT: begin
            rsp_strobe_in     = 1'b1;
            rsp_in.code       = (rd_idx_ff < cnt_ff) ? rd_data : fill_lat_ff;
            rsp_in.code_total = tot_w[8:0];
            rsp_in.status     = ST_CODE;
            rsp_in.last       = rd_next >= total_ff;
            rd_idx_in         = rd_next;
            if (rd_next >= total_ff) begin
               ready_in  = 1'b0;
               clear_msg = 1'b1;
            end
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (put_en && !ovf_ff) begin
         if (cnt_ff >= CW'(MAX_CODE_COUNT)) ovf_in = 1'b1;
         else cnt_in = cnt_ff + CW'(1);
      end
      if (clear_pend || clear_msg) begin
         pend_in      = '0;
         pend_cnt_in  = 3'd0;
         flush_idx_in = 3'd0;
      end
      if (clear_msg) begin
         cnt_in    = '0;
         token_in  = 1'b0;
         space_in  = 1'b0;
         ovf_in    = 1'b0;
         rd_idx_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         flush_next_ff <= S_IDLE;
         pend_ff       <= '0;
         pend_cnt_ff   <= 3'd0;
         flush_idx_ff  <= 3'd0;
         cnt_ff        <= '0;
         total_ff      <= '0;
         rd_idx_ff     <= '0;
         token_ff      <= 1'b0;
         space_ff      <= 1'b0;
         ovf_ff        <= 1'b0;
         ready_ff      <= 1'b0;
         min_size_ff   <= 9'd0;
         fill_code_ff  <= SPACE_CODE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         flush_next_ff <= flush_next_in;
         pend_ff       <= pend_in;
         pend_cnt_ff   <= pend_cnt_in;
         flush_idx_ff  <= flush_idx_in;
         cnt_ff        <= cnt_in;
         total_ff      <= total_in;
         rd_idx_ff     <= rd_idx_in;
         token_ff      <= token_in;
         space_ff      <= space_in;
         ovf_ff        <= ovf_in;
         ready_ff      <= ready_in;
         min_size_ff   <= min_size_in;
         fill_code_ff  <= fill_code_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      item_ff     <= item_in;
      fill_lat_ff <= fill_lat_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

endmodule
